[rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit: command and order
// codes, result field widths, the result record and the engine status.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int CMD_BITS     = 3;
   localparam int RES_NUM_BITS = 34;
   localparam int RES_DEN_BITS = 33;
   localparam int ORDER_BITS   = 2;

   // Command codes
   localparam logic [CMD_BITS-1:0] CMD_ADD   = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_SUB   = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_MUL   = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_DIV   = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_NEG   = 3'd4;
   localparam logic [CMD_BITS-1:0] CMD_RECIP = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_CMP   = 3'd6;

   // Compare result codes
   localparam logic [ORDER_BITS-1:0] ORD_LESS    = 2'd0;
   localparam logic [ORDER_BITS-1:0] ORD_EQUAL   = 2'd1;
   localparam logic [ORDER_BITS-1:0] ORD_GREATER = 2'd2;

   // Status codes
   localparam logic ST_OK    = 1'b0;
   localparam logic ST_ERROR = 1'b1;

   // Saturation limits of the result fields
   localparam logic [RES_NUM_BITS-1:0] NUM_MAX = {1'b0, {(RES_NUM_BITS-1){1'b1}}};
   localparam logic [RES_NUM_BITS-1:0] NUM_MIN = {1'b1, {(RES_NUM_BITS-1){1'b0}}};
   localparam logic [RES_DEN_BITS-1:0] DEN_MAX = {RES_DEN_BITS{1'b1}};

   typedef struct packed {
      logic signed [RES_NUM_BITS-1:0] res_num;
      logic [RES_DEN_BITS-1:0]        res_den;
      logic [ORDER_BITS-1:0]          order;
      logic                           status;
   } result_type;

   // Status of the gcd / exact-division engine
   typedef struct packed {
      logic busy;
      logic done;
   } eng_status_type;

endpackage

[rtl/rau_chan_if.sv]
// ----------------------------------------------------------------------------
// rau_req_if / rau_rsp_if
// Valid/ready channels of the rational arithmetic unit: operand channel
// and result channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface rau_req_if #(parameter int OPERAND_BITS = 16);
   logic                             valid;
   logic                             ready;
   logic [rau_pkg::CMD_BITS-1:0]     command;
   logic signed [OPERAND_BITS-1:0]   a_num;
   logic signed [OPERAND_BITS-1:0]   a_den;
   logic signed [OPERAND_BITS-1:0]   b_num;
   logic signed [OPERAND_BITS-1:0]   b_den;

   modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [rau_pkg::RES_NUM_BITS-1:0] res_num;
   logic [rau_pkg::RES_DEN_BITS-1:0]        res_den;
   logic [rau_pkg::ORDER_BITS-1:0]          order;
   logic                                    status;

   modport source (output valid, res_num, res_den, order, status, input ready);
   modport sink   (input valid, res_num, res_den, order, status, output ready);
endinterface

[rtl/rau_mult.sv]
// ----------------------------------------------------------------------------
// rau_mult
// Shared signed multiplier with registered product; one product per cycle,
// available the cycle after the operands are presented.
// ----------------------------------------------------------------------------
module rau_mult #(
   parameter int IW = 17
) (
   input  logic                   clock,
   input  logic signed [IW-1:0]   op_a,
   input  logic signed [IW-1:0]   op_b,
   output logic signed [2*IW-1:0] prod
);

   logic signed [2*IW-1:0] prod_in;
   logic signed [2*IW-1:0] prod_ff;

   // full-width signed product
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

[rtl/rau_gcd_div.sv]
// ----------------------------------------------------------------------------
// rau_gcd_div
// Reduction engine: binary gcd g of two nonzero magnitudes, then, unless g is
// one, exact restoring division of both by g, on one shared subtractor.
// ----------------------------------------------------------------------------
module rau_gcd_div #(
   parameter int MW = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [MW-1:0]           num_mag,
   input  logic [MW-1:0]           den_mag,
   output rau_pkg::eng_status_type eng_status,
   output logic [MW-1:0]           num_red,
   output logic [MW-1:0]           den_red
);

   localparam int CW = $clog2(MW + 1);

   localparam logic [2:0] E_IDLE  = 3'd0;
   localparam logic [2:0] E_TZ    = 3'd1;
   localparam logic [2:0] E_LOOP  = 3'd2;
   localparam logic [2:0] E_SCALE = 3'd3;
   localparam logic [2:0] E_DIVN  = 3'd4;
   localparam logic [2:0] E_DIVD  = 3'd5;
   localparam logic [2:0] E_DONE  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [MW-1:0] x_ff, x_in;
   logic [MW-1:0] y_ff, y_in;
   logic [MW-1:0] g_ff, g_in;
   logic [MW-1:0] ns_ff, ns_in;
   logic [MW-1:0] ds_ff, ds_in;
   logic [MW-1:0] quo_ff, quo_in;
   logic [MW-1:0] rem_ff, rem_in;
   logic [MW-1:0] nq_ff, nq_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic          in_div;
   logic [MW:0]   sub_a;
   logic [MW:0]   sub_b;
   logic [MW+1:0] sub_d;
   logic          borrow;
   logic [MW-1:0] abs_diff;
   logic [MW-1:0] div_rem;
   logic [MW-1:0] div_quo;
   logic [MW-1:0] scaled;

   // shared subtractor: gcd difference or division trial
   assign in_div = (state_ff == E_DIVN) || (state_ff == E_DIVD);
   assign sub_a  = in_div ? {rem_ff, quo_ff[MW-1]} : {1'b0, y_ff};
   assign sub_b  = in_div ? {1'b0, g_ff} : {1'b0, x_ff};
   assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow = sub_d[MW+1];

   assign abs_diff = borrow ? (MW'(0) - sub_d[MW-1:0]) : sub_d[MW-1:0];
   assign div_rem  = borrow ? sub_a[MW-1:0] : sub_d[MW-1:0];
   assign div_quo  = {quo_ff[MW-2:0], ~borrow};
   assign scaled   = x_ff << k_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      g_in     = g_ff;
      ns_in    = ns_ff;
      ds_in    = ds_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      nq_in    = nq_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               x_in     = num_mag;
               y_in     = den_mag;
               ns_in    = num_mag;
               ds_in    = den_mag;
               k_in     = '0;
               state_in = E_TZ;
            end
         end
         // strip common factors of two
         E_TZ: begin
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + CW'(1);
            end else begin
               state_in = E_LOOP;
            end
         end
         // odd-part gcd: shift out twos, else subtract and halve
         E_LOOP: begin
            priority if (y_ff == '0) begin
               state_in = E_SCALE;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else begin
               if (borrow) begin
                  x_in = y_ff;
               end
               y_in = abs_diff >> 1;
            end
         end
         E_SCALE: begin
            g_in = scaled;
            if (scaled == MW'(1)) begin
               nq_in    = ns_ff;
               quo_in   = ds_ff;
               state_in = E_DONE;
            end else begin
               rem_in   = '0;
               quo_in   = ns_ff;
               cnt_in   = CW'(MW);
               state_in = E_DIVN;
            end
         end
         E_DIVN: begin
            rem_in = div_rem;
            quo_in = div_quo;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               nq_in    = div_quo;
               quo_in   = ds_ff;
               rem_in   = '0;
               cnt_in   = CW'(MW);
               state_in = E_DIVD;
            end
         end
         E_DIVD: begin
            rem_in = div_rem;
            quo_in = div_quo;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = E_DONE;
            end
         end
         E_DONE: begin
            state_in = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      g_ff   <= g_in;
      ns_ff  <= ns_in;
      ds_ff  <= ds_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      nq_ff  <= nq_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
   end

   assign eng_status.busy = (state_ff != E_IDLE);
   assign eng_status.done = (state_ff == E_DONE);
   assign num_red         = nq_ff;
   assign den_red         = quo_ff;

endmodule

[rtl/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Fraction add, subtract, multiply, divide, negate, reciprocal and compare
// with the result reduced by the gcd of numerator and denominator.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries a command and two fractions a_num/a_den, b_num/b_den;
//   a transfer happens when valid and ready are both high. rsp_chan carries
//   one result per request: reduced res_num/res_den, order for compare and
//   status (set for a zero denominator, divide by zero or unused command).
//   One request is in work at a time; req_chan.ready is high only while the
//   sequencer is idle, and a finished result may still be waiting on rsp_chan.
//   Errors skip the products and go straight to the result hand-over; compare
//   results finish after the products, zero results at the reduce step and
//   others after the reduction. The reduction is a binary gcd on a shared
//   subtractor followed by two restoring divisions of 2*OPERAND_BITS steps
//   each, left out when the gcd is one. Products come from one shared
//   registered multiplier, three per request that is not an error. Reset
//   clears the sequencer and empties the result register. A stalled
//   rsp_chan holds its result; the next result waits in the sequencer.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
   parameter int OPERAND_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   rau_req_if.sink    req_chan,
   rau_rsp_if.source  rsp_chan
);

   localparam int OW  = OPERAND_BITS + 1;
   localparam int PW  = 2 * OW;
   localparam int MW  = 2 * OPERAND_BITS;
   localparam int XW  = (MW + 1 > rau_pkg::RES_NUM_BITS + 1) ? MW + 1
                                                             : rau_pkg::RES_NUM_BITS + 1;
   localparam int DXW = (MW > rau_pkg::RES_DEN_BITS + 1) ? MW : rau_pkg::RES_DEN_BITS + 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL0   = 3'd1;
   localparam logic [2:0] S_MUL1   = 3'd2;
   localparam logic [2:0] S_MUL2   = 3'd3;
   localparam logic [2:0] S_SIGN   = 3'd4;
   localparam logic [2:0] S_REDUCE = 3'd5;
   localparam logic [2:0] S_WAIT   = 3'd6;
   localparam logic [2:0] S_FINISH = 3'd7;

   localparam logic signed [OW-1:0] ONE       = OW'(1);
   localparam logic signed [OW-1:0] MINUS_ONE = '1;

   logic [2:0]                    state_ff, state_in;
   logic [rau_pkg::CMD_BITS-1:0]  cmd_ff, cmd_in;
   logic signed [OW-1:0]          an_ff, an_in;
   logic signed [OW-1:0]          ad_ff, ad_in;
   logic signed [OW-1:0]          bn_ff, bn_in;
   logic signed [OW-1:0]          bd_ff, bd_in;
   logic signed [PW-1:0]          acc_ff, acc_in;
   logic signed [PW-1:0]          num_ff, num_in;
   logic signed [PW-1:0]          den_ff, den_in;
   logic                          neg_ff, neg_in;
   rau_pkg::result_type           pend_ff, pend_in;
   rau_pkg::result_type           rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic signed [OW-1:0]          a_num_x, a_den_x, b_num_x, b_den_x;
   logic signed [OW-1:0]          an_n, ad_n, bn_n, bd_n;
   logic                          req_err;
   logic                          req_xfer;

   logic signed [OW-1:0]          mul_a, mul_b;
   logic signed [PW-1:0]          prod;

   logic                          eng_start;
   rau_pkg::eng_status_type       eng_status;
   logic [MW-1:0]                 eng_num, eng_den;
   logic signed [PW-1:0]          num_abs;
   logic [MW-1:0]                 num_red_w;
   logic [MW-1:0]                 den_red_w;

   logic signed [MW:0]            num_s;
   logic signed [XW-1:0]          num_x;
   logic [DXW-1:0]                den_x;
   logic                          num_fits, den_fits;
   logic [rau_pkg::RES_NUM_BITS-1:0] num_sat;
   logic [rau_pkg::RES_DEN_BITS-1:0] den_sat;

   // operand capture: widen, move the denominator sign to the numerator
   assign a_num_x = OW'(req_chan.a_num);
   assign a_den_x = OW'(req_chan.a_den);
   assign b_num_x = OW'(req_chan.b_num);
   assign b_den_x = OW'(req_chan.b_den);
   assign an_n    = a_den_x[OW-1] ? -a_num_x : a_num_x;
   assign ad_n    = a_den_x[OW-1] ? -a_den_x : a_den_x;
   assign bn_n    = b_den_x[OW-1] ? -b_num_x : b_num_x;
   assign bd_n    = b_den_x[OW-1] ? -b_den_x : b_den_x;
   assign req_xfer = req_chan.valid && req_chan.ready;

   // request errors
   always_comb begin
      unique case (req_chan.command)
         rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_MUL, rau_pkg::CMD_CMP:
            req_err = (a_den_x == '0) || (b_den_x == '0);
         rau_pkg::CMD_DIV:
            req_err = (a_den_x == '0) || (b_den_x == '0) || (b_num_x == '0);
         rau_pkg::CMD_NEG:
            req_err = (a_den_x == '0);
         rau_pkg::CMD_RECIP:
            req_err = (a_den_x == '0) || (a_num_x == '0);
         default:
            req_err = 1'b1;
      endcase
   end

   // multiplier operand schedule: step 0 and 1 build the numerator, step 2
   // the denominator
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MUL0: begin
            unique case (cmd_ff)
               rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_CMP, rau_pkg::CMD_DIV: begin
                  mul_a = an_ff;
                  mul_b = bd_ff;
               end
               rau_pkg::CMD_MUL: begin
                  mul_a = an_ff;
                  mul_b = bn_ff;
               end
               rau_pkg::CMD_NEG: begin
                  mul_a = an_ff;
                  mul_b = MINUS_ONE;
               end
               rau_pkg::CMD_RECIP: begin
                  mul_a = ad_ff;
                  mul_b = ONE;
               end
               default: ;
            endcase
         end
         S_MUL1: begin
            unique case (cmd_ff)
               rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_CMP: begin
                  mul_a = bn_ff;
                  mul_b = ad_ff;
               end
               default: ;
            endcase
         end
         S_MUL2: begin
            unique case (cmd_ff)
               rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_MUL, rau_pkg::CMD_CMP: begin
                  mul_a = ad_ff;
                  mul_b = bd_ff;
               end
               rau_pkg::CMD_DIV: begin
                  mul_a = ad_ff;
                  mul_b = bn_ff;
               end
               rau_pkg::CMD_NEG: begin
                  mul_a = ad_ff;
                  mul_b = ONE;
               end
               rau_pkg::CMD_RECIP: begin
                  mul_a = an_ff;
                  mul_b = ONE;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   rau_mult #(
      .IW (OW)
   ) u_mult (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // magnitudes for the reduction engine
   assign num_abs = num_ff[PW-1] ? -num_ff : num_ff;
   assign eng_num = num_abs[MW-1:0];
   assign eng_den = den_ff[MW-1:0];

   rau_gcd_div #(
      .MW (MW)
   ) u_gcd_div (
      .clock      (clock),
      .reset      (reset),
      .start      (eng_start),
      .num_mag    (eng_num),
      .den_mag    (eng_den),
      .eng_status (eng_status),
      .num_red    (num_red_w),
      .den_red    (den_red_w)
   );

   // sign restore and saturation of the reduced fraction
   assign num_s    = neg_ff ? -$signed({1'b0, num_red_w}) : $signed({1'b0, num_red_w});
   assign num_x    = XW'(num_s);
   assign num_fits = (&num_x[XW-1:rau_pkg::RES_NUM_BITS-1])
                     || !(|num_x[XW-1:rau_pkg::RES_NUM_BITS-1]);
   assign num_sat  = num_fits ? num_x[rau_pkg::RES_NUM_BITS-1:0]
                   : (num_x[XW-1] ? rau_pkg::NUM_MIN : rau_pkg::NUM_MAX);
   assign den_x    = DXW'(den_red_w);
   assign den_fits = !(|den_x[DXW-1:rau_pkg::RES_DEN_BITS]);
   assign den_sat  = den_fits ? den_x[rau_pkg::RES_DEN_BITS-1:0] : rau_pkg::DEN_MAX;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      acc_in       = acc_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      eng_start    = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in = req_chan.command;
               an_in  = an_n;
               ad_in  = ad_n;
               bn_in  = bn_n;
               bd_in  = bd_n;
               if (req_err) begin
                  pend_in.res_num = '0;
                  pend_in.res_den = '0;
                  pend_in.order   = rau_pkg::ORD_LESS;
                  pend_in.status  = rau_pkg::ST_ERROR;
                  state_in        = S_FINISH;
               end else begin
                  state_in = S_MUL0;
               end
            end
         end
         S_MUL0: begin
            state_in = S_MUL1;
         end
         S_MUL1: begin
            acc_in   = prod;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            if (cmd_ff == rau_pkg::CMD_SUB || cmd_ff == rau_pkg::CMD_CMP) begin
               acc_in = acc_ff - prod;
            end else begin
               acc_in = acc_ff + prod;
            end
            state_in = S_SIGN;
         end
         // compare finishes here; otherwise make the denominator positive
         S_SIGN: begin
            if (cmd_ff == rau_pkg::CMD_CMP) begin
               pend_in.res_num = '0;
               pend_in.res_den = rau_pkg::RES_DEN_BITS'(1);
               pend_in.status  = rau_pkg::ST_OK;
               priority if (acc_ff[PW-1]) begin
                  pend_in.order = rau_pkg::ORD_LESS;
               end else if (acc_ff == '0) begin
                  pend_in.order = rau_pkg::ORD_EQUAL;
               end else begin
                  pend_in.order = rau_pkg::ORD_GREATER;
               end
               state_in = S_FINISH;
            end else begin
               if (prod[PW-1]) begin
                  num_in = -acc_ff;
                  den_in = -prod;
               end else begin
                  num_in = acc_ff;
                  den_in = prod;
               end
               state_in = S_REDUCE;
            end
         end
         // zero is 0/1; anything else goes through the engine
         S_REDUCE: begin
            if (num_ff == '0) begin
               pend_in.res_num = '0;
               pend_in.res_den = rau_pkg::RES_DEN_BITS'(1);
               pend_in.order   = rau_pkg::ORD_LESS;
               pend_in.status  = rau_pkg::ST_OK;
               state_in        = S_FINISH;
            end else begin
               neg_in    = num_ff[PW-1];
               eng_start = 1'b1;
               state_in  = S_WAIT;
            end
         end
         S_WAIT: begin
            if (eng_status.done) begin
               pend_in.res_num = num_sat;
               pend_in.res_den = den_sat;
               pend_in.order   = rau_pkg::ORD_LESS;
               pend_in.status  = rau_pkg::ST_OK;
               state_in        = S_FINISH;
            end
         end
         // hand over to the result register once it is free
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      an_ff   <= an_in;
      ad_ff   <= ad_in;
      bn_ff   <= bn_in;
      bd_ff   <= bd_in;
      acc_ff  <= acc_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // channel outputs
   assign req_chan.ready   = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.res_num = rsp_ff.res_num;
   assign rsp_chan.res_den = rsp_ff.res_den;
   assign rsp_chan.order   = rsp_ff.order;
   assign rsp_chan.status  = rsp_ff.status;

`ifndef SYNTHESIS
   // an error result has a zero numerator and a zero denominator
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == rau_pkg::ST_ERROR
      |-> rsp_chan.res_den == '0 && rsp_chan.res_num == '0)
      else $error("error result with nonzero fields");

   // a good result never has a zero denominator
   a_ok_den : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == rau_pkg::ST_OK |-> rsp_chan.res_den != '0)
      else $error("good result with zero denominator");

   // only one request in work at a time
   a_one_item : assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("second request taken while busy");

   // the engine finishes only while the sequencer waits for it
   a_done_wait : assert property (@(posedge clock) disable iff (reset)
      eng_status.done |-> state_ff == S_WAIT)
      else $error("engine done outside wait state");

   // the engine is free whenever a new reduction is launched
   a_eng_free : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_REDUCE |-> !eng_status.busy)
      else $error("engine busy at launch");
`endif

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rational_arithmetic_unit. Directed and random
// fraction operations are sent over the request channel. A behavioural
// predictor works out the reduced result of each accepted transfer, and a
// checker compares it field by field with every result transfer. Both
// channels idle in random bursts, except in the back-to-back test.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OPERAND_BITS = 16;
   localparam logic [rau_pkg::CMD_BITS-1:0] CMD_UNUSED = 3'd7;
   localparam int TAIL_CYCLES = 8 * OPERAND_BITS + 30;
   localparam int REPORT_LIMIT = 100;

   typedef logic signed [OPERAND_BITS-1:0] operand_type;
   typedef logic [rau_pkg::CMD_BITS-1:0] command_type;

   logic clock = 1'b0;
   logic reset;

   rau_req_if #(.OPERAND_BITS(OPERAND_BITS)) req_chan ();
   rau_rsp_if rsp_chan ();

   rational_arithmetic_unit #(.OPERAND_BITS(OPERAND_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rau_pkg::result_type pending_results[$];
   int                  error_count = 0;
   bit                  idling_on   = 1'b1;
   int                  stall_left  = 0;

   // Clock: 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Reduced-fraction predictor
   function automatic rau_pkg::result_type rational_result(command_type cmd,
                                                           operand_type a_num_i,
                                                           operand_type a_den_i,
                                                           operand_type b_num_i,
                                                           operand_type b_den_i);
      longint              an, ad, bn, bd, n, d, lhs, rhs, x, y, t;
      longint              num_hi, num_lo, den_hi;
      bit                  uses_b;
      rau_pkg::result_type res;
      an = a_num_i;
      ad = a_den_i;
      bn = b_num_i;
      bd = b_den_i;
      num_hi = longint'(rau_pkg::NUM_MAX);
      num_lo = -num_hi - 1;
      den_hi = longint'(rau_pkg::DEN_MAX);
      n = 0;
      d = 1;
      // error result unless overwritten
      res.res_num = '0;
      res.res_den = '0;
      res.order   = rau_pkg::ORD_LESS;
      res.status  = rau_pkg::ST_ERROR;
      uses_b = (cmd <= rau_pkg::CMD_DIV) || (cmd == rau_pkg::CMD_CMP);
      if (cmd == CMD_UNUSED || ad == 0 || (uses_b && bd == 0))
         return res;
      if (ad < 0) begin
         an = -an;
         ad = -ad;
      end
      if (bd < 0) begin
         bn = -bn;
         bd = -bd;
      end
      case (cmd)
         rau_pkg::CMD_ADD: begin
            n = an * bd + bn * ad;
            d = ad * bd;
         end
         rau_pkg::CMD_SUB: begin
            n = an * bd - bn * ad;
            d = ad * bd;
         end
         rau_pkg::CMD_MUL: begin
            n = an * bn;
            d = ad * bd;
         end
         rau_pkg::CMD_DIV: begin
            if (bn == 0)
               return res;
            n = an * bd;
            d = ad * bn;
         end
         rau_pkg::CMD_NEG: begin
            n = -an;
            d = ad;
         end
         rau_pkg::CMD_RECIP: begin
            if (an == 0)
               return res;
            n = ad;
            d = an;
         end
         default: begin
            lhs = an * bd;
            rhs = bn * ad;
            res.res_num = '0;
            res.res_den = rau_pkg::RES_DEN_BITS'(1);
            res.status  = rau_pkg::ST_OK;
            res.order   = (lhs < rhs) ? rau_pkg::ORD_LESS
                        : ((lhs == rhs) ? rau_pkg::ORD_EQUAL : rau_pkg::ORD_GREATER);
            return res;
         end
      endcase
      // sign to the numerator, then divide out the gcd
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      if (n == 0) begin
         d = 1;
      end else begin
         x = (n < 0) ? -n : n;
         y = d;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         n = n / x;
         d = d / x;
      end
      if (n > num_hi) n = num_hi;
      if (n < num_lo) n = num_lo;
      if (d > den_hi) d = den_hi;
      res.res_num = n[rau_pkg::RES_NUM_BITS-1:0];
      res.res_den = d[rau_pkg::RES_DEN_BITS-1:0];
      res.status  = rau_pkg::ST_OK;
      return res;
   endfunction

   // Random operand: mostly small or full range, some extremes
   function automatic operand_type pick_operand();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: begin
            case ($urandom_range(0, 4))
               0: return operand_type'(-32768);
               1: return operand_type'(32767);
               2: return operand_type'(-1);
               3: return operand_type'(0);
               default: return operand_type'(1);
            endcase
         end
         1, 2, 3: return operand_type'(int'($urandom_range(0, 40)) - 20);
         default: return operand_type'($urandom);
      endcase
   endfunction

   function automatic command_type pick_command();
      if ($urandom_range(0, 39) == 0)
         return CMD_UNUSED;
      return command_type'($urandom_range(0, 6));
   endfunction

   // Send one request; valid stays high after the transfer for back-to-back use
   task automatic send_operands(command_type cmd, operand_type an, operand_type ad,
                                operand_type bn, operand_type bd);
      int gap;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.command <= cmd;
      req_chan.a_num   <= an;
      req_chan.a_den   <= ad;
      req_chan.b_num   <= bn;
      req_chan.b_den   <= bd;
      do @(posedge clock); while (!req_chan.ready);
      pending_results.push_back(rational_result(cmd, an, ad, bn, bd));
   endtask

   task automatic release_request();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      release_request();
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Result side: random stall bursts
   always @(negedge clock) begin
      if (!idling_on) begin
         rsp_chan.ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = $urandom_range(1, 6) - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Result checker: each transfer against the oldest expectation
   always @(posedge clock) begin
      rau_pkg::result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $error("result transfer with nothing expected: res_num %0d res_den %0d",
                      rsp_chan.res_num, rsp_chan.res_den);
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.res_num !== want.res_num) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $error("res_num: expected %0d, got %0d", want.res_num, rsp_chan.res_num);
            end
            if (rsp_chan.res_den !== want.res_den) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $error("res_den: expected %0d, got %0d", want.res_den, rsp_chan.res_den);
            end
            if (rsp_chan.order !== want.order) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $error("order: expected %0d, got %0d", want.order, rsp_chan.order);
            end
            if (rsp_chan.status !== want.status) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
            end
         end
      end
   end

   // Extremes, every command and each error case
   task automatic test_directed();
      send_operands(rau_pkg::CMD_ADD, 1, 2, 1, 3);
      send_operands(rau_pkg::CMD_SUB, 1, 2, 1, 2);           // zero result -> 0/1
      send_operands(rau_pkg::CMD_MUL, -32768, 32767, -32768, 32767);
      send_operands(rau_pkg::CMD_DIV, 32767, -32768, -32768, 32767);
      send_operands(rau_pkg::CMD_NEG, -32768, 1, 0, 0);      // b ignored, zero b_den ok
      send_operands(rau_pkg::CMD_RECIP, -3, 6, 0, 0);
      send_operands(rau_pkg::CMD_CMP, 1, 3, 2, 6);           // equal
      send_operands(rau_pkg::CMD_CMP, -1, 2, 1, 2);          // less
      send_operands(rau_pkg::CMD_CMP, 3, -4, -1, 1);         // greater
      send_operands(rau_pkg::CMD_ADD, 1, 0, 1, 1);           // zero a_den
      send_operands(rau_pkg::CMD_MUL, 1, 1, 1, 0);           // zero b_den
      send_operands(rau_pkg::CMD_DIV, 5, 7, 0, 3);           // divide by zero
      send_operands(rau_pkg::CMD_RECIP, 0, 5, 1, 1);         // reciprocal of zero
      send_operands(CMD_UNUSED, 1, 1, 1, 1);
      send_operands(rau_pkg::CMD_NEG, 0, -5, 3, 3);
      send_operands(rau_pkg::CMD_ADD, -32768, -32768, -32768, -32768);
      send_operands(rau_pkg::CMD_SUB, 32767, 1, -32768, 1);
      send_operands(rau_pkg::CMD_CMP, -32768, 1, 32767, 1);
      send_operands(rau_pkg::CMD_CMP, 32767, 1, -32768, 1);
      send_operands(rau_pkg::CMD_RECIP, -32768, -1, 0, 0);
      send_operands(rau_pkg::CMD_DIV, -32768, 32767, 1, -32768);
      send_operands(rau_pkg::CMD_CMP, 1, 1, 1, 0);           // compare, zero b_den
      send_operands(rau_pkg::CMD_NEG, 7, 0, 1, 1);           // negate, zero a_den
      send_operands(rau_pkg::CMD_MUL, 0, -7, 5, 3);
   endtask

   task automatic test_random_mix(int count);
      repeat (count)
         send_operands(pick_command(), pick_operand(), pick_operand(),
                       pick_operand(), pick_operand());
   endtask

   // Operands sharing a factor so that the reduction does real work
   task automatic test_common_factors(int count);
      int k;
      repeat (count) begin
         k = $urandom_range(1, 200);
         send_operands(command_type'($urandom_range(0, 6)),
                       operand_type'(k * (int'($urandom_range(0, 300)) - 150)),
                       operand_type'(k * (int'($urandom_range(0, 300)) - 150)),
                       operand_type'(int'($urandom_range(1, 150))
                                     * (int'($urandom_range(0, 200)) - 100)),
                       operand_type'(int'($urandom_range(1, 150))
                                     * (int'($urandom_range(0, 200)) - 100)));
      end
   endtask

   // Sender holds off until every result is back, several times over
   task automatic test_drain_pauses();
      repeat (3) begin
         test_random_mix(50);
         wait_drained();
      end
   endtask

   task automatic test_back_to_back(int count);
      idling_on = 1'b0;
      test_random_mix(count);
   endtask

   // Sequence of tests
   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.command = '0;
      req_chan.a_num   = '0;
      req_chan.a_den   = '0;
      req_chan.b_num   = '0;
      req_chan.b_den   = '0;
      rsp_chan.ready   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_mix(500);
      test_drain_pauses();
      test_common_factors(300);
      test_back_to_back(300);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[rational_arithmetic_unit.f]
rtl/rau_pkg.sv
rtl/rau_chan_if.sv
rtl/rau_mult.sv
rtl/rau_gcd_div.sv
rtl/rational_arithmetic_unit.sv
verif/testbench.sv
